>>> design/hbp_pkg.sv
`timescale 1ns / 1ps

package hbp_pkg;

	// Fixed field widths of the request and response items
	localparam int CODE_W      = 16;
	localparam int LEN_IN_W    = 5;
	localparam int SYM_W       = 7;
	localparam int BYTE_W      = 8;
	localparam int GROUP_BYTES = 3;
	localparam int GROUP_W     = GROUP_BYTES * BYTE_W;

	// Parameter defaults
	localparam int MAX_CODE_LEN_DEF = 16;
	localparam int SYMBOL_COUNT_DEF = 128;

	typedef enum logic {
		FUNC_LOAD   = 1'b0,
		FUNC_ENCODE = 1'b1
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [SYM_W-1:0]     symbol;
		logic [CODE_W-1:0]    code_bits;
		logic [LEN_IN_W-1:0]  code_len;
		logic                 last;
	} hbp_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              stream_end;
	} hbp_rsp_t;

	// Control carried alongside the table read
	typedef struct packed {
		logic encode;
		logic last;
	} hbp_ctl_t;

	// Bytes produced by one request, first byte in the top bits
	typedef struct packed {
		logic [GROUP_W-1:0] bytes;
		logic [1:0]         cnt;
		logic               last;
	} hbp_group_t;

	// Longest code length that is ever stored
	function automatic int code_cap(input int max_len);
		return (max_len < CODE_W) ? max_len : CODE_W;
	endfunction

	// Bits needed to hold a stored code length
	function automatic int len_width(input int max_len);
		return $clog2(code_cap(max_len) + 1);
	endfunction

endpackage

>>> design/hbp_code_table.sv
`timescale 1ns / 1ps

module hbp_code_table #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic                                         rd_en,
	input  logic [$clog2(SYMBOL_COUNT)-1:0]              addr,
	input  logic [hbp_pkg::code_cap(MAX_CODE_LEN)-1:0]   wr_code,
	input  logic [hbp_pkg::len_width(MAX_CODE_LEN)-1:0]  wr_len,
	output logic [hbp_pkg::code_cap(MAX_CODE_LEN)-1:0]   rd_code,
	output logic [hbp_pkg::len_width(MAX_CODE_LEN)-1:0]  rd_len
);
	import hbp_pkg::*;

	localparam int CAP     = code_cap(MAX_CODE_LEN);
	localparam int LW      = len_width(MAX_CODE_LEN);
	localparam int ENTRY_W = CAP + LW;

	logic [ENTRY_W-1:0] mem_q [SYMBOL_COUNT];
	logic [ENTRY_W-1:0] entry_s1;

	// Write on load, read on encode; read data is registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= {wr_len, wr_code};
		end
		if (rd_en) begin
			entry_s1 <= mem_q[addr];
		end
	end

	assign rd_code = entry_s1[CAP-1:0];
	assign rd_len  = entry_s1[ENTRY_W-1:CAP];

endmodule

>>> design/hbp_packer.sv
`timescale 1ns / 1ps

module hbp_packer #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         advance,
	input  hbp_pkg::hbp_ctl_t                            ctl,
	input  logic [hbp_pkg::code_cap(MAX_CODE_LEN)-1:0]   entry_code,
	input  logic [hbp_pkg::len_width(MAX_CODE_LEN)-1:0]  entry_len,
	output hbp_pkg::hbp_group_t                          group
);
	import hbp_pkg::*;

	logic [BYTE_W-1:0]  acc_q;
	logic [2:0]         fill_q;
	logic [4:0]         n_bits;
	logic [CODE_W-1:0]  aligned;
	logic [GROUP_W-1:0] win;
	logic [4:0]         total;
	logic [1:0]         full;
	logic [2:0]         rem;
	logic               flush;
	logic [BYTE_W-1:0]  acc_nxt;

	// Left-align the code word and drop it in after the bits already held
	always_comb begin
		n_bits  = ctl.encode ? 5'(entry_len) : 5'd0;
		aligned = CODE_W'(entry_code) << (5'd16 - n_bits);
		win     = {acc_q, 16'b0} | ({aligned, 8'b0} >> fill_q);
		total   = 5'(fill_q) + n_bits;
		full    = total[4:3];
		rem     = total[2:0];
		flush   = ctl.last && (rem != 3'd0);
		case (full)
			2'd0:    acc_nxt = win[23:16];
			2'd1:    acc_nxt = win[15:8];
			default: acc_nxt = win[7:0];
		endcase
	end

	assign group.bytes = win;
	assign group.cnt   = full + 2'(flush);
	assign group.last  = ctl.last;

	// Advance the partial byte; the end of a run starts an empty byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else if (advance) begin
			if (ctl.last) begin
				acc_q  <= '0;
				fill_q <= '0;
			end else begin
				acc_q  <= acc_nxt;
				fill_q <= rem;
			end
		end
	end

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q & (8'hFF >> fill_q)) == 8'h00)
		else $error("partial byte holds bits below its fill count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.last |=> fill_q == 3'd0 && acc_q == 8'h00)
		else $error("partial byte not cleared after end of run");

endmodule

>>> design/hbp_out_queue.sv
`timescale 1ns / 1ps

module hbp_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hbp_pkg::hbp_group_t group,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output hbp_pkg::hbp_rsp_t   out_rsp
);
	import hbp_pkg::*;

	logic               valid_q;
	logic [GROUP_W-1:0] bytes_q;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;
	logic               last_q;
	logic               final_byte;
	logic               take;

	assign final_byte = (idx_q == (cnt_q - 2'd1));
	assign take       = valid_q && out_ready;
	assign free       = !valid_q || (out_ready && final_byte);

	// Hold one group and hand out its bytes in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (push) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (take) begin
			if (final_byte) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			bytes_q <= group.bytes;
			cnt_q   <= group.cnt;
			last_q  <= group.last;
		end
	end

	// Select the current byte and mark the final one
	always_comb begin
		case (idx_q)
			2'd0:    out_rsp.out_byte = bytes_q[23:16];
			2'd1:    out_rsp.out_byte = bytes_q[15:8];
			default: out_rsp.out_byte = bytes_q[7:0];
		endcase
		out_rsp.run_last   = final_byte;
		out_rsp.stream_end = final_byte && last_q;
	end

	assign out_valid = valid_q;

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> cnt_q != 2'd0 && idx_q < cnt_q)
		else $error("byte index outside the held group");

endmodule

>>> design/huffman_bit_packer_unit.sv
`timescale 1ns / 1ps

// Huffman bit packer.
// Requests arrive on in_valid/in_ready/in_req. A load request writes the code
// word and length of one symbol into the code table; an encode request looks
// the symbol up and appends its code bits, first bit into the next free
// bit of the current byte. A request with last set flushes a partial byte,
// zero padded. Each request yields zero to three bytes on
// out_valid/out_ready/out_rsp; run_last marks the final byte of a request,
// stream_end that byte when the request carried last.
// An accepted request waits in the packer stage with its registered table
// entry and moves its bytes to the output group register when that register
// is free; its bytes are handed out from there.
// Throughput: one request per cycle while the packer stage is not blocked.
// A request that makes no byte passes straight through unless a request
// ahead of it is blocked. Bytes leave one per cycle from the output group
// register while out_ready is high, so the input stalls while a request's
// bytes are still leaving when the next request also emits.
// Reset clears the partial byte and the output register; table entries are
// undefined until loaded. When the receiver stalls, the held byte stays put
// and in_ready drops once the packer stage is blocked behind it.
module huffman_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hbp_pkg::SYMBOL_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hbp_pkg::hbp_req_t in_req,
	output logic              out_valid,
	input  logic              out_ready,
	output hbp_pkg::hbp_rsp_t out_rsp
);
	import hbp_pkg::*;

	localparam int CAP = code_cap(MAX_CODE_LEN);
	localparam int LW  = len_width(MAX_CODE_LEN);
	localparam int AW  = $clog2(SYMBOL_COUNT);

	logic            in_acc;
	logic            in_range;
	logic [AW-1:0]   addr;
	logic [LW-1:0]   wr_len;
	logic            valid_s1;
	hbp_ctl_t        ctl_s1;
	logic [CAP-1:0]  entry_code;
	logic [LW-1:0]   entry_len;
	hbp_group_t      group;
	logic            grp_free;
	logic            s1_adv;
	logic            push;

	// Decode the request
	assign in_acc   = in_valid && in_ready;
	assign in_range = 32'(in_req.symbol) < SYMBOL_COUNT;
	assign addr     = AW'(in_req.symbol);
	assign wr_len   = (32'(in_req.code_len) > CAP) ? LW'(CAP) : LW'(in_req.code_len);

	hbp_code_table #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_COUNT (SYMBOL_COUNT)
	) u_table (
		.clk     (clk),
		.wr_en   (in_acc && in_req.func == FUNC_LOAD && in_range),
		.rd_en   (in_acc && in_req.func == FUNC_ENCODE && in_range),
		.addr    (addr),
		.wr_code (in_req.code_bits[CAP-1:0]),
		.wr_len  (wr_len),
		.rd_code (entry_code),
		.rd_len  (entry_len)
	);

	// Advance the packer stage when it makes no byte or the output has room
	assign s1_adv   = valid_s1 && (group.cnt == 2'd0 || grp_free);
	assign push     = s1_adv && group.cnt != 2'd0;
	assign in_ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1.encode <= (in_req.func == FUNC_ENCODE) && in_range;
			ctl_s1.last   <= in_req.last;
		end
	end

	hbp_packer #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (s1_adv),
		.ctl        (ctl_s1),
		.entry_code (entry_code),
		.entry_len  (entry_len),
		.group      (group)
	);

	hbp_out_queue u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.group     (group),
		.free      (grp_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> grp_free)
		else $error("group pushed while output register busy");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(ctl_s1))
		else $error("stalled packer stage lost its request");

endmodule

>>> bench/huffman_bit_packer_unit_test.sv
`timescale 1ns / 1ps

module huffman_bit_packer_unit_test;
	import hbp_pkg::*;

	localparam int LEN_CAP      = 16;
	localparam int SYMBOLS      = 128;
	localparam int LONG_HOLD    = 100;
	localparam int RANDOM_ITEMS = 200;

	typedef struct {
		hbp_req_t req;
		bit       drain_first;
	} pending_req_t;

	typedef struct {
		logic [CODE_W-1:0]   word;
		logic [LEN_IN_W-1:0] len;
	} code_entry_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	hbp_req_t in_req    = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	hbp_rsp_t out_rsp;

	// Requests waiting to be offered, and bytes waiting to come out
	pending_req_t req_backlog[$];
	hbp_rsp_t     bytes_due[$];

	// Shadow of the code table and the byte being filled
	code_entry_t  shadow_table[SYMBOLS];
	logic [7:0]   shadow_byte;
	int unsigned  shadow_fill;

	int send_gap;
	int take_gap;
	int hold_left;
	bit long_hold_done;

	int unsigned loads_seen;
	int unsigned encodes_seen;
	int unsigned lasts_seen;
	int unsigned input_stalls;
	int unsigned bytes_checked;
	int unsigned mismatches;

	huffman_bit_packer_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_rsp  (out_rsp)
	);

	always #2 clk = ~clk;

	// Mostly short idles, now and then a long one
	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Apply one accepted request to the shadow state and queue the bytes it makes
	task automatic pack_request(input hbp_req_t r);
		hbp_rsp_t    made[$];
		hbp_rsp_t    b;
		code_entry_t e;
		int unsigned n;
		logic [LEN_IN_W-1:0] len;
		if (r.func == FUNC_LOAD) begin
			loads_seen++;
			len = (r.code_len > LEN_CAP) ? LEN_IN_W'(LEN_CAP) : r.code_len;
			shadow_table[r.symbol].word = r.code_bits;
			shadow_table[r.symbol].len  = len;
		end else begin
			encodes_seen++;
			e = shadow_table[r.symbol];
			n = e.len;
			for (int i = int'(n) - 1; i >= 0; i--) begin
				shadow_byte[7 - shadow_fill] = e.word[i];
				shadow_fill++;
				if (shadow_fill == 8) begin
					b = '{out_byte: shadow_byte, run_last: 1'b0, stream_end: 1'b0};
					made.push_back(b);
					shadow_byte = '0;
					shadow_fill = 0;
				end
			end
		end
		// Flush the partial byte, zero padded
		if (r.last) begin
			lasts_seen++;
			if (shadow_fill != 0) begin
				b = '{out_byte: shadow_byte, run_last: 1'b0, stream_end: 1'b0};
				made.push_back(b);
			end
			shadow_byte = '0;
			shadow_fill = 0;
		end
		if (made.size() != 0) begin
			made[made.size() - 1].run_last   = 1'b1;
			made[made.size() - 1].stream_end = r.last;
		end
		foreach (made[i])
			bytes_due.push_back(made[i]);
	endtask

	// Drive requests from the backlog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req   <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				pack_request(in_req);
			if (in_valid && !in_ready)
				input_stalls++;
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (req_backlog.size() != 0 &&
						!(req_backlog[0].drain_first && bytes_due.size() != 0)) begin
					in_req   <= req_backlog[0].req;
					in_valid <= 1'b1;
					send_gap <= idle_len();
					void'(req_backlog.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take and check output bytes; hold off once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		hbp_rsp_t want;
		if (!arst_n) begin
			out_ready      <= 1'b0;
			take_gap       <= 0;
			hold_left      <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (bytes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected byte %02h run_last %b stream_end %b",
							$realtime, out_rsp.out_byte, out_rsp.run_last,
							out_rsp.stream_end);
				end else begin
					want = bytes_due.pop_front();
					bytes_checked++;
					if (out_rsp.out_byte !== want.out_byte ||
							out_rsp.run_last !== want.run_last ||
							out_rsp.stream_end !== want.stream_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: byte %0d expected %02h/%b/%b got %02h/%b/%b",
								$realtime, bytes_checked, want.out_byte, want.run_last,
								want.stream_end, out_rsp.out_byte, out_rsp.run_last,
								out_rsp.stream_end);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!long_hold_done && bytes_checked >= 40) begin
				long_hold_done <= 1'b1;
				hold_left      <= LONG_HOLD;
				out_ready      <= 1'b0;
			end else if (take_gap != 0) begin
				take_gap  <= take_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_valid && out_ready)
					take_gap <= idle_len();
			end
		end
	end

	task automatic add_req(input func_t f, input int unsigned sym, input int unsigned bits,
			input int unsigned len, input bit last, input bit drain);
		pending_req_t p;
		p.req.func      = f;
		p.req.symbol    = SYM_W'(sym);
		p.req.code_bits = CODE_W'(bits);
		p.req.code_len  = LEN_IN_W'(len);
		p.req.last      = last;
		p.drain_first   = drain;
		req_backlog.push_back(p);
	endtask

	// Build the stimulus, release reset, wait for the stream to drain
	initial begin : stimulus
		bit          loaded[SYMBOLS];
		int unsigned kind;
		int unsigned sym;
		int unsigned len;
		int unsigned count;
		int unsigned planned;
		bit          drain_marked;

		shadow_byte  = '0;
		shadow_fill  = 0;
		drain_marked = 1'b0;
		foreach (shadow_table[i])
			shadow_table[i] = '{word: '0, len: '0};

		// Full-length, single-bit, zero-length, overlong and odd entries
		add_req(FUNC_LOAD, 0, 16'hFFFF, 16, 0, 0);
		add_req(FUNC_LOAD, 127, 16'h0000, 1, 0, 0);
		add_req(FUNC_LOAD, 5, 16'h1234, 0, 0, 0);
		add_req(FUNC_LOAD, 9, 16'hA5C3, 31, 0, 0);
		add_req(FUNC_LOAD, 3, 16'h0005, 3, 0, 0);
		add_req(FUNC_LOAD, 64, 16'h2AAA, 7, 0, 0);
		foreach (loaded[i])
			loaded[i] = 1'b0;
		loaded[0] = 1; loaded[127] = 1; loaded[5] = 1; loaded[9] = 1;
		loaded[3] = 1; loaded[64] = 1; loaded[7] = 1;
		add_req(FUNC_ENCODE, 0, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 0, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 127, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 5, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 3, 0, 0, 1, 0);
		// Last with the byte empty: end marker goes on the last full byte
		add_req(FUNC_ENCODE, 9, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 9, 0, 0, 1, 0);
		// Last on an item that makes no byte at all
		add_req(FUNC_ENCODE, 5, 0, 0, 1, 0);
		// Last on a load flushes the partial byte
		add_req(FUNC_ENCODE, 127, 0, 0, 0, 0);
		add_req(FUNC_LOAD, 7, 16'h00F0, 8, 1, 0);
		// Three bytes from one request
		add_req(FUNC_ENCODE, 127, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 0, 0, 0, 1, 0);
		add_req(FUNC_ENCODE, 64, 0, 0, 0, 0);
		add_req(FUNC_ENCODE, 7, 0, 0, 1, 0);
		add_req(FUNC_LOAD, 127, 16'hFFFF, 5, 0, 0);

		// Random part: mostly complete messages, some noise and open streams
		planned = 0;
		while (planned < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				count = $urandom_range(0, 4);
				repeat (count) begin
					sym = $urandom_range(0, SYMBOLS - 1);
					kind = $urandom_range(0, 99);
					len = (kind < 70) ? $urandom_range(1, 16) :
						(kind < 80) ? 0 : $urandom_range(17, 31);
					add_req(FUNC_LOAD, sym, $urandom_range(0, 16'hFFFF), len, 0,
						!drain_marked && planned >= 120);
					if (planned >= 120)
						drain_marked = 1'b1;
					loaded[sym] = 1'b1;
					planned++;
				end
				count = $urandom_range(1, 10);
				for (int i = 0; i < count; i++) begin
					do sym = $urandom_range(0, SYMBOLS - 1); while (!loaded[sym]);
					add_req(FUNC_ENCODE, sym, $urandom_range(0, 16'hFFFF),
						$urandom_range(0, 31), i == count - 1, 0);
					planned++;
				end
			end else if (kind < 90) begin
				sym = $urandom_range(0, SYMBOLS - 1);
				add_req(FUNC_LOAD, sym, $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 31), $urandom_range(0, 1), 0);
				loaded[sym] = 1'b1;
				planned++;
			end else begin
				do sym = $urandom_range(0, SYMBOLS - 1); while (!loaded[sym]);
				add_req(FUNC_ENCODE, sym, $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 31), $urandom_range(0, 1), 0);
				planned++;
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (bytes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d loads, %0d encodes, %0d flush requests; %0d bytes checked.",
			loads_seen, encodes_seen, lasts_seen, bytes_checked);
		$display("Input was held back for %0d cycles; %0d mismatches.",
			input_stalls, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
